// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/dds_pkg.sv -----
// types and constants of the dds waveform generator
package dds_pkg;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_TRIANGLE = 2'd2
    } t_wave_mode;

    typedef enum logic [1:0] {
        CFG_WAVE_MODE    = 2'd0,
        CFG_FREQ_WORD    = 2'd1,
        CFG_PHASE_OFFSET = 2'd2,
        CFG_AMPLITUDE    = 2'd3
    } t_cfg_idx;

    localparam int unsigned PHASE_W = 32;
    localparam int unsigned INDEX_W = 24;
    localparam int unsigned AMP_W   = 15;
    localparam int unsigned VALUE_W = 16;

    // pi/2 in q30
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

endpackage

// ----- hw/rtl/dds_waveform_generator.sv -----
// dds waveform generator: sine, square and triangle samples from a sample index
// five register stages lie between input word and output word
// throughput: one word per cycle while the output is not stalled; stage 1 holds the 24x32 phase multiplier
// a stalled output holds its word while bubbles in earlier stages still fill
// reset: synchronous active low, clears the pipeline valid bits and all config registers to 0
`include "assert_macros.svh"

module dds_waveform_generator #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [1:0]                        i_cfg_index,
    input  logic [31:0]                       i_cfg_data,
    input  logic                              i_sample_valid,
    output logic                              o_sample_ready,
    input  logic [dds_pkg::INDEX_W-1:0]       i_sample_index,
    output logic                              o_value_valid,
    input  logic                              i_value_ready,
    output logic signed [dds_pkg::VALUE_W-1:0] o_sample_value
);

    import dds_pkg::*;

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int SCL_W = 30 + IDX_W;
    localparam int NSTG  = 5;

    typedef logic [AMP_W-1:0] t_sine_tab [0:SINE_TABLE_DEPTH];

    function automatic logic [63:0] f_sin_q30(input logic [63:0] x);
        logic [63:0] term;
        logic [63:0] sum;
        term = x;
        sum  = x;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd6;
        sum  = sum - term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd42;
        sum  = sum - term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd110;
        sum  = sum - term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd156;
        sum  = sum + term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd210;
        sum  = sum - term;
        term = ((((term * x) >> 30) * x) >> 30) / 64'd272;
        sum  = sum + term;
        return sum;
    endfunction

    function automatic t_sine_tab f_build_tab();
        t_sine_tab   tab;
        logic [63:0] x;
        logic [63:0] v;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x = (64'(k) * Q30_HALF_PI) / 64'(SINE_TABLE_DEPTH);
            v = (f_sin_q30(x) * 64'd32767 + 64'd536870912) >> 30;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            tab[k] = v[AMP_W-1:0];
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = f_build_tab();

    // config registers
    t_wave_mode         r_wave_mode;
    logic [PHASE_W-1:0] r_freq_word;
    logic [PHASE_W-1:0] r_phase_offset;
    logic [AMP_W-1:0]   r_amplitude;

    // pipeline control
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;
    logic            w_in_acc;
    logic            w_out_acc;

    // stage 1
    logic [PHASE_W-1:0] n_s1_base;
    logic [PHASE_W-1:0] r_s1_base;
    t_wave_mode         r_s1_mode;
    logic [AMP_W-1:0]   r_s1_amp;

    // stage 2
    logic [PHASE_W-1:0] w_s2_phase;
    logic [SCL_W-1:0]   w_s2_scaled;
    logic [IDX_W-1:0]   w_s2_idx;
    logic [IDX_W-1:0]   n_s2_addr;
    logic [PHASE_W-1:0] n_s2_dist;
    logic [IDX_W-1:0]   r_s2_addr;
    logic [PHASE_W-1:0] r_s2_dist;
    logic               r_s2_neg;
    t_wave_mode         r_s2_mode;
    logic [AMP_W-1:0]   r_s2_amp;

    // stage 3
    logic [AMP_W-1:0]   r_s3_sin;
    logic [47:0]        r_s3_tri;
    logic               r_s3_neg;
    t_wave_mode         r_s3_mode;
    logic [AMP_W-1:0]   r_s3_amp;

    // stage 4
    logic [47:0]        n_s4_tri_sum;
    logic [29:0]        r_s4_prod;
    logic [AMP_W-1:0]   r_s4_tri;
    logic               r_s4_neg;
    t_wave_mode         r_s4_mode;
    logic [AMP_W-1:0]   r_s4_amp;

    // stage 5
    logic [AMP_W-1:0]   w_s5_q0;
    logic [16:0]        w_s5_rem;
    logic [AMP_W:0]     w_s5_quot;
    logic [AMP_W-1:0]   w_s5_mag;
    logic [VALUE_W-1:0] n_s5_value;
    logic [VALUE_W-1:0] r_s5_value;
    t_wave_mode         r_s5_mode;
    logic [AMP_W-1:0]   r_s5_amp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_mode    <= WAVE_SINE;
            r_freq_word    <= '0;
            r_phase_offset <= '0;
            r_amplitude    <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WAVE_MODE:    r_wave_mode    <= t_wave_mode'(i_cfg_data[1:0]);
                CFG_FREQ_WORD:    r_freq_word    <= i_cfg_data;
                CFG_PHASE_OFFSET: r_phase_offset <= i_cfg_data;
                CFG_AMPLITUDE:    r_amplitude    <= i_cfg_data[AMP_W-1:0];
                default:          r_amplitude    <= r_amplitude;
            endcase
        end
    end

    // a stage loads when it is empty or the next one moves
    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || i_value_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_sample_ready = w_en[0];
    assign o_value_valid  = r_vld[NSTG-1];
    assign o_sample_value = $signed(r_s5_value);
    assign w_in_acc       = i_sample_valid && o_sample_ready;
    assign w_out_acc      = o_value_valid && i_value_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_sample_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: phase step product
    assign n_s1_base = PHASE_W'(PHASE_W'(i_sample_index) * r_freq_word);

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s1_base <= n_s1_base;
            r_s1_mode <= r_wave_mode;
            r_s1_amp  <= r_amplitude;
        end
    end

    // stage 2: phase, table address, triangle distance
    always_comb begin
        w_s2_phase  = r_s1_base + r_phase_offset;
        w_s2_scaled = SCL_W'(w_s2_phase[29:0]) * SCL_W'(SINE_TABLE_DEPTH)
                    + SCL_W'(32'h2000_0000);
        w_s2_idx    = w_s2_scaled[SCL_W-1:30];
        n_s2_addr   = w_s2_phase[30] ? (IDX_W'(SINE_TABLE_DEPTH) - w_s2_idx) : w_s2_idx;
        if (r_s1_base[31] && (r_s1_base[30:0] != '0)) begin
            n_s2_dist = PHASE_W'(0) - r_s1_base;
        end else begin
            n_s2_dist = r_s1_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s2_addr <= n_s2_addr;
            r_s2_dist <= n_s2_dist;
            r_s2_neg  <= w_s2_phase[31];
            r_s2_mode <= r_s1_mode;
            r_s2_amp  <= r_s1_amp;
        end
    end

    // stage 3: table read, triangle product
    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s3_sin  <= SINE_TAB[r_s2_addr];
            r_s3_tri  <= 48'({r_s2_amp, 1'b0}) * 48'(r_s2_dist);
            r_s3_neg  <= r_s2_neg;
            r_s3_mode <= r_s2_mode;
            r_s3_amp  <= r_s2_amp;
        end
    end

    // stage 4: sine scaling, triangle rounding
    assign n_s4_tri_sum = r_s3_tri + 48'h0000_8000_0000;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_s4_prod <= 30'(r_s3_amp) * 30'(r_s3_sin) + 30'd16383;
            r_s4_tri  <= n_s4_tri_sum[46:32];
            r_s4_neg  <= r_s3_neg;
            r_s4_mode <= r_s3_mode;
            r_s4_amp  <= r_s3_amp;
        end
    end

    // stage 5: divide by 32767, select and sign
    always_comb begin
        w_s5_q0  = r_s4_prod[29:15];
        w_s5_rem = 17'(r_s4_prod[14:0]) + 17'(w_s5_q0);
        if (w_s5_rem >= 17'd65534) begin
            w_s5_quot = 16'(w_s5_q0) + 16'd2;
        end else if (w_s5_rem >= 17'd32767) begin
            w_s5_quot = 16'(w_s5_q0) + 16'd1;
        end else begin
            w_s5_quot = 16'(w_s5_q0);
        end
        case (r_s4_mode)
            WAVE_SINE: begin
                w_s5_mag   = w_s5_quot[AMP_W-1:0];
                n_s5_value = r_s4_neg ? (VALUE_W'(0) - VALUE_W'(w_s5_mag)) : VALUE_W'(w_s5_mag);
            end
            WAVE_SQUARE: begin
                w_s5_mag   = r_s4_amp;
                n_s5_value = r_s4_neg ? (VALUE_W'(0) - VALUE_W'(w_s5_mag)) : VALUE_W'(w_s5_mag);
            end
            WAVE_TRIANGLE: begin
                w_s5_mag   = r_s4_tri;
                n_s5_value = VALUE_W'(w_s5_mag);
            end
            default: begin
                w_s5_mag   = '0;
                n_s5_value = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_s5_value <= n_s5_value;
            r_s5_mode  <= r_s4_mode;
            r_s5_amp   <= r_s4_amp;
        end
    end

    `ASSERT_IMPLIES(a_occupancy, i_clk, i_rst_n, $past(i_rst_n),
        $countones(r_vld) == $past($countones(r_vld)) + int'($past(w_in_acc))
            - int'($past(w_out_acc)),
        "pipeline occupancy does not match accepted words")

    `ASSERT_IMPLIES(a_peak, i_clk, i_rst_n, o_value_valid,
        (o_sample_value <= $signed({1'b0, r_s5_amp}))
            && (o_sample_value >= -$signed({1'b0, r_s5_amp})),
        "sample exceeds amplitude")

    `ASSERT_IMPLIES(a_tri_unipolar, i_clk, i_rst_n,
        o_value_valid && (r_s5_mode == WAVE_TRIANGLE), !o_sample_value[VALUE_W-1],
        "triangle sample is negative")

    `ASSERT_IMPLIES(a_square_level, i_clk, i_rst_n,
        o_value_valid && (r_s5_mode == WAVE_SQUARE),
        (o_sample_value == $signed({1'b0, r_s5_amp}))
            || (o_sample_value == -$signed({1'b0, r_s5_amp})),
        "square sample is not at full level")

endmodule
